// ===== sv/mst_pkg.sv =====
// ---------------------------------------------------------------------------
// Max segment tree package
// Shared types and constants for the max segment tree search block.
// ---------------------------------------------------------------------------
`default_nettype none

package mst_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 11;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // Most negative two's complement value: the reset content of every node.
  localparam logic [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef struct packed {
    logic                      operation;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] found_position;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/mst_node_ram.sv =====
// ---------------------------------------------------------------------------
// Node store
// Single write port, single read port memory holding the node maxima.
// ---------------------------------------------------------------------------
`default_nettype none

module mst_node_ram #(
  parameter int ADDR_W = 11
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [ADDR_W-1:0]          waddr,
  input  wire logic [mst_pkg::VALUE_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0]          raddr,
  output logic [mst_pkg::VALUE_W-1:0]      rdata
);
  import mst_pkg::*;

  logic [VALUE_W-1:0] mem [2**ADDR_W];
  logic [VALUE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/mst_ctrl.sv =====
// ---------------------------------------------------------------------------
// Tree sequencer
// Walks the node store for updates and searches, using one shared compare.
// ---------------------------------------------------------------------------
`default_nettype none

module mst_ctrl #(
  parameter int CAPACITY = 1024,
  parameter int NODE_W   = 11
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire mst_pkg::in_item_t           in_item,
  input  wire logic                        in_fire,
  output logic                             busy,
  output logic                             res_valid,
  output mst_pkg::out_item_t               res_item,
  input  wire logic                        res_take,
  output logic                             ram_we,
  output logic [NODE_W-1:0]                ram_waddr,
  output logic [mst_pkg::VALUE_W-1:0]      ram_wdata,
  output logic [NODE_W-1:0]                ram_raddr,
  input  wire logic [mst_pkg::VALUE_W-1:0] ram_rdata
);
  import mst_pkg::*;

  localparam int LEAF_W = NODE_W - 1;
  localparam logic [NODE_W-1:0] LEAVES = NODE_W'(1) << LEAF_W;
  localparam logic [NODE_W-1:0] ROOT   = NODE_W'(1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_UPD, S_QCHK, S_QDESC, S_QCLIMB, S_RESULT
  } state_t;

  state_t             state_r,  state_nxt;
  logic [NODE_W-1:0]  node_r,   node_nxt;
  logic [VALUE_W-1:0] val_r,    val_nxt;
  out_item_t          res_r,    res_nxt;

  logic               ge;
  logic [VALUE_W-1:0] mx;
  logic [NODE_W-1:0]  parent;
  logic [NODE_W-1:0]  pick;
  logic [NODE_W-1:0]  fin_node;
  logic [NODE_W-1:0]  fin_pos;
  logic               fin_ok;
  logic [POS_W-1:0]   start;
  logic [NODE_W-1:0]  in_leaf;
  out_item_t          fin_res;

  // The shared comparator: stored value against running maximum or threshold.
  assign ge     = $signed(ram_rdata) >= $signed(val_r);
  assign mx     = ge ? ram_rdata : val_r;
  assign parent = node_r >> 1;
  assign pick   = ge ? node_r : (node_r | NODE_W'(1));

  assign start   = (in_item.position == '0) ? POS_W'(1) : in_item.position;
  assign in_leaf = LEAVES + NODE_W'(start) - NODE_W'(1);

  assign fin_node = (state_r == S_QDESC) ? pick : node_r;
  assign fin_pos  = {1'b0, fin_node[LEAF_W-1:0]} + NODE_W'(1);
  assign fin_ok   = 32'(fin_pos) <= CAPACITY;
  assign fin_res.found          = fin_ok;
  assign fin_res.found_position = fin_ok ? POS_W'(fin_pos) : '0;

  always_comb begin
    state_nxt = state_r;
    node_nxt  = node_r;
    val_nxt   = val_r;
    res_nxt   = res_r;
    ram_we    = 1'b0;
    ram_waddr = node_r;
    ram_wdata = val_r;
    ram_raddr = node_r;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = MOST_NEG;
        node_nxt  = node_r + NODE_W'(1);
        if (&node_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          val_nxt = in_item.operand_value;
          if (in_item.operation == OP_UPDATE) begin
            if (in_item.position != '0 && 32'(in_item.position) <= CAPACITY) begin
              ram_we    = 1'b1;
              ram_waddr = in_leaf;
              ram_wdata = in_item.operand_value;
              ram_raddr = in_leaf ^ NODE_W'(1);
              node_nxt  = in_leaf;
              state_nxt = S_UPD;
            end
          end else if (32'(start) > CAPACITY) begin
            res_nxt   = '0;
            state_nxt = S_RESULT;
          end else begin
            ram_raddr = in_leaf;
            node_nxt  = in_leaf;
            state_nxt = S_QCHK;
          end
        end
      end
      S_UPD: begin
        ram_we    = 1'b1;
        ram_waddr = parent;
        ram_wdata = mx;
        val_nxt   = mx;
        node_nxt  = parent;
        ram_raddr = parent ^ NODE_W'(1);
        if (parent == ROOT) begin
          state_nxt = S_IDLE;
        end
      end
      S_QCHK: begin
        if (!ge) begin
          state_nxt = S_QCLIMB;
        end else if (node_r[NODE_W-1]) begin
          res_nxt   = fin_res;
          state_nxt = S_RESULT;
        end else begin
          ram_raddr = node_r << 1;
          node_nxt  = node_r << 1;
          state_nxt = S_QDESC;
        end
      end
      S_QDESC: begin
        if (pick[NODE_W-1]) begin
          res_nxt   = fin_res;
          state_nxt = S_RESULT;
        end else begin
          ram_raddr = pick << 1;
          node_nxt  = pick << 1;
        end
      end
      S_QCLIMB: begin
        if (node_r == ROOT) begin
          res_nxt   = '0;
          state_nxt = S_RESULT;
        end else if (node_r[0]) begin
          node_nxt = parent;
        end else begin
          ram_raddr = node_r | NODE_W'(1);
          node_nxt  = node_r | NODE_W'(1);
          state_nxt = S_QCHK;
        end
      end
      S_RESULT: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      node_r  <= '0;
    end else begin
      state_r <= state_nxt;
      node_r  <= node_nxt;
    end
    val_r <= val_nxt;
    res_r <= res_nxt;
  end

  assign busy      = state_r != S_IDLE;
  assign res_valid = state_r == S_RESULT;
  assign res_item  = res_r;

endmodule

`default_nettype wire

// ===== sv/max_segment_tree_first_at_least.sv =====
// ---------------------------------------------------------------------------
// Max segment tree, first position at least a threshold
// Top level: node store, sequencer and the registered result stage.
// ---------------------------------------------------------------------------
// The block keeps a max segment tree over CAPACITY signed positions and works
// on one transaction at a time. After reset it clears its node store in a
// pass over all 2*LEAVES nodes (LEAVES being CAPACITY rounded up to a power
// of two) and holds in_stall high meanwhile. An update writes the leaf in
// its accept cycle, then each level towards the root in turn, reading
// siblings through the single read port of the node store. A query whose
// start lies beyond capacity goes straight to its result; any other query
// climbs from the start leaf, stepping to the right neighbour, reading it
// and moving up level by level, until a right neighbour holds a large
// enough maximum, then descends one level per cycle, every node read passing
// through the same memory port and the same comparator. Updates and updates
// to an out of range position give no result; an out of range update is
// absorbed in its accept cycle. Each query gives one result transaction,
// which sits in an output register so the next transaction can be accepted
// while it waits to be taken.
// ---------------------------------------------------------------------------
`default_nettype none

module max_segment_tree_first_at_least #(
  parameter int CAPACITY = 1024
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire mst_pkg::in_item_t   in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mst_pkg::out_item_t       out_data
);
  import mst_pkg::*;

  // Node indices run from 1 to 2*LEAVES-1, so one extra bit over the leaves.
  localparam int NODE_W = $clog2(CAPACITY) + 1;

  logic               busy;
  logic               in_fire;
  logic               res_valid;
  out_item_t          res_item;
  logic               res_take;
  logic               ram_we;
  logic [NODE_W-1:0]  ram_waddr;
  logic [VALUE_W-1:0] ram_wdata;
  logic [NODE_W-1:0]  ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;

  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r,  out_data_nxt;

  assign in_stall = busy;
  assign in_fire  = in_valid && !busy;

  // A finished result may move into the output register when it is empty or
  // when its current transaction is being taken in this cycle.
  assign res_take = !out_valid_r || !out_stall;

  mst_node_ram #(
    .ADDR_W (NODE_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mst_ctrl #(
    .CAPACITY (CAPACITY),
    .NODE_W   (NODE_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_data),
    .in_fire   (in_fire),
    .busy      (busy),
    .res_valid (res_valid),
    .res_item  (res_item),
    .res_take  (res_take),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== sv/mst_checker.sv =====
// ---------------------------------------------------------------------------
// Port checker
// Concurrent assertions on the top level ports, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module mst_checker #(
  parameter int CAPACITY = 1024
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire mst_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire mst_pkg::out_item_t out_data
);
  import mst_pkg::*;

  // A result held back by the receiver stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // A miss always reports position zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.found_position == '0)
    else $error("miss with nonzero position");

  // A hit lies within the real positions, never on a padding leaf.
  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.found |->
      out_data.found_position != '0 && 32'(out_data.found_position) <= CAPACITY)
    else $error("hit outside capacity");

  // A query keeps the block busy for at least the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.operation == OP_QUERY |=> in_stall)
    else $error("query accepted without going busy");

  // Reset starts the clearing pass, during which nothing is accepted.
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("ready straight after reset");

endmodule

bind max_segment_tree_first_at_least mst_checker #(.CAPACITY(CAPACITY)) u_mst_checker (.*);

`default_nettype wire
